// ----- sv/otas_pkg.sv -----
// Package for the output-aligned time stepper.
// Holds the sequencer states, register indexes, reset values and shared types.
// No dependencies.
`timescale 1ns / 1ps

package otas_pkg;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_PER   = 3;
  localparam int unsigned PER_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_END_TIME      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_PERIOD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT    = 3'd4;

  localparam logic [PER_IDX_W-1:0] PER_MAP    = 2'd0;
  localparam logic [PER_IDX_W-1:0] PER_LOG    = 2'd1;
  localparam logic [PER_IDX_W-1:0] PER_SCREEN = 2'd2;

  localparam logic [CFG_W-1:0] RST_END_TIME   = 32'd100;
  localparam logic [CFG_W-1:0] RST_PERIOD     = 32'd10;
  localparam logic [CFG_W-1:0] RST_STEP_LIMIT = 32'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_WAIT,
    ST_CMP,
    ST_SUM,
    ST_CLAMP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/otas_div.sv -----
// Restoring remainder unit, one dividend bit per cycle.
// Used by the time stepper to find time modulo each output period.
// Depends on otas_pkg.
`timescale 1ns / 1ps

module otas_div #(
  parameter int unsigned DVD_W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DVD_W-1:0]        dividend_i,
  input  logic [otas_pkg::CFG_W-1:0] divisor_i,
  output otas_pkg::div_stat_t     stat_o,
  output logic [otas_pkg::CFG_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam int unsigned RW    = otas_pkg::CFG_W;

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [RW-1:0]    dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      rem_d = ge ? diff[RW-1:0] : trial[RW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ----- sv/output_aligned_time_stepper_top.sv -----
// Top level of the output-aligned time stepper: sequencer, state and result register.
// Depends on otas_pkg and otas_div.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   requested_step_i
//   out      output     out_valid_o / out_stall_i time_now_o, step_taken_o, step_number_o,
//                                                 map_due_o, log_due_o, screen_due_o, halt_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// The three periods of an item go one after another through one restoring remainder
// unit, one bit per cycle; a zero period skips its division. in_stall_o is high from
// acceptance until the result enters the output register; a stalled result holds there
// while the next item runs.
// Reset gives time zero, step count zero, halt low and the register reset values.
`timescale 1ns / 1ps

module output_aligned_time_stepper_top #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [otas_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [otas_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [31:0]                       requested_step_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [31:0]                       time_now_o,
  output logic [31:0]                       step_taken_o,
  output logic [31:0]                       step_number_o,
  output logic                              map_due_o,
  output logic                              log_due_o,
  output logic                              screen_due_o,
  output logic                              halt_o
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned EW = (TW > 32) ? TW : 32;
  localparam int unsigned SW = EW + 1;
  localparam int unsigned NP = otas_pkg::NUM_PER;

  otas_pkg::state_e state_q, state_d;

  logic [otas_pkg::CFG_W-1:0] end_q, map_per_q, log_per_q, scr_per_q, limit_q;

  logic [TW-1:0]                 time_q;
  logic [31:0]                   cnt_q;
  logic                          halt_q;
  logic [31:0]                   req_q;
  logic [TW-1:0]                 target_q;
  logic [TW-1:0]                 sum_q;
  logic [TW-1:0]                 tn_q;
  logic [NP-1:0][TW-1:0]         dl_q;
  logic [NP-1:0]                 ok_q;
  logic [otas_pkg::PER_IDX_W-1:0] idx_q;

  logic                          out_valid_q;
  logic [31:0]                   out_time_q, out_taken_q, out_num_q;
  logic [NP-1:0]                 out_due_q;
  logic                          out_halt_q;

  logic [otas_pkg::CFG_W-1:0]    per_sel;
  logic                          div_start;
  otas_pkg::div_stat_t           div_stat;
  logic [otas_pkg::CFG_W-1:0]    div_rem;
  logic                          accept;
  logic                          slot_free;
  logic                          out_load;
  logic                          last_per;
  logic [TW-1:0]                 base;
  logic [SW-1:0]                 dl_sum;
  logic                          dl_ok;
  logic [SW-1:0]                 tsum;
  logic [TW-1:0]                 tsum_sat;
  logic [TW-1:0]                 tmin;
  logic [31:0]                   cnt_inc;
  logic                          halt_d;
  logic [NP-1:0]                 due;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q     <= otas_pkg::RST_END_TIME;
      map_per_q <= otas_pkg::RST_PERIOD;
      log_per_q <= otas_pkg::RST_PERIOD;
      scr_per_q <= otas_pkg::RST_PERIOD;
      limit_q   <= otas_pkg::RST_STEP_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        otas_pkg::CFG_END_TIME:      end_q     <= cfg_data_i;
        otas_pkg::CFG_MAP_PERIOD:    map_per_q <= cfg_data_i;
        otas_pkg::CFG_LOG_PERIOD:    log_per_q <= cfg_data_i;
        otas_pkg::CFG_SCREEN_PERIOD: scr_per_q <= cfg_data_i;
        otas_pkg::CFG_STEP_LIMIT:    limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx_q)
      otas_pkg::PER_MAP:    per_sel = map_per_q;
      otas_pkg::PER_LOG:    per_sel = log_per_q;
      otas_pkg::PER_SCREEN: per_sel = scr_per_q;
      default:              per_sel = scr_per_q;
    endcase
  end

  otas_div #(
    .DVD_W(TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (time_q),
    .divisor_i  (per_sel),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  // datapath terms
  always_comb begin
    base     = time_q - TW'(div_rem);
    dl_sum   = SW'(base) + SW'(per_sel);
    dl_ok    = (dl_sum >> TW) == '0;
    tsum     = SW'(time_q) + SW'(req_q);
    tsum_sat = ((tsum >> TW) != '0) ? {TW{1'b1}} : tsum[TW-1:0];
    tmin     = (sum_q < target_q) ? sum_q : target_q;
    cnt_inc  = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;
    halt_d   = halt_q || (cnt_inc >= limit_q) || (EW'(tn_q) >= EW'(end_q));
    for (int k = 0; k < NP; k++) begin
      due[k] = ok_q[k] && (tn_q == dl_q[k]);
    end
    last_per  = idx_q == otas_pkg::PER_SCREEN;
    slot_free = !out_valid_q || !out_stall_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otas_pkg::ST_IDLE:   if (in_valid_i) state_d = otas_pkg::ST_PREP;
      otas_pkg::ST_PREP:   state_d = (per_sel == '0) ? otas_pkg::ST_CMP : otas_pkg::ST_WAIT;
      otas_pkg::ST_WAIT:   if (div_stat.done) state_d = otas_pkg::ST_CMP;
      otas_pkg::ST_CMP:    state_d = last_per ? otas_pkg::ST_SUM : otas_pkg::ST_PREP;
      otas_pkg::ST_SUM:    state_d = otas_pkg::ST_CLAMP;
      otas_pkg::ST_CLAMP:  state_d = otas_pkg::ST_FINISH;
      otas_pkg::ST_FINISH: if (slot_free) state_d = otas_pkg::ST_IDLE;
      default:             state_d = otas_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      otas_pkg::ST_IDLE:   in_stall_o = 1'b0;
      otas_pkg::ST_PREP:   div_start  = per_sel != '0;
      otas_pkg::ST_FINISH: out_load   = slot_free;
      default: ;
    endcase
    accept = in_valid_i && !in_stall_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= otas_pkg::ST_IDLE;
      time_q      <= '0;
      cnt_q       <= '0;
      halt_q      <= 1'b0;
      idx_q       <= otas_pkg::PER_MAP;
      ok_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q <= otas_pkg::PER_MAP;
      end
      if (state_q == otas_pkg::ST_PREP && per_sel == '0) begin
        ok_q[idx_q] <= 1'b0;
      end
      if (state_q == otas_pkg::ST_WAIT && div_stat.done) begin
        ok_q[idx_q] <= dl_ok;
      end
      if (state_q == otas_pkg::ST_CMP && !last_per) begin
        idx_q <= idx_q + 1'b1;
      end
      if (out_load) begin
        time_q <= tn_q;
        cnt_q  <= cnt_inc;
        halt_q <= halt_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= requested_step_i;
      target_q <= TW'(end_q);
    end
    if (state_q == otas_pkg::ST_WAIT && div_stat.done) begin
      dl_q[idx_q] <= dl_sum[TW-1:0];
    end
    if (state_q == otas_pkg::ST_CMP && ok_q[idx_q] && dl_q[idx_q] < target_q) begin
      target_q <= dl_q[idx_q];
    end
    if (state_q == otas_pkg::ST_SUM) begin
      sum_q <= tsum_sat;
    end
    if (state_q == otas_pkg::ST_CLAMP) begin
      tn_q <= (tmin < time_q) ? time_q : tmin;
    end
    if (out_load) begin
      out_time_q  <= 32'(tn_q);
      out_taken_q <= 32'(tn_q - time_q);
      out_num_q   <= cnt_inc;
      out_due_q   <= due;
      out_halt_q  <= halt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign time_now_o    = out_time_q;
  assign step_taken_o  = out_taken_q;
  assign step_number_o = out_num_q;
  assign map_due_o     = out_due_q[otas_pkg::PER_MAP];
  assign log_due_o     = out_due_q[otas_pkg::PER_LOG];
  assign screen_due_o  = out_due_q[otas_pkg::PER_SCREEN];
  assign halt_o        = out_halt_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt cleared");

  a_time_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> time_q >= $past(time_q))
    else $error("time went backward");

  a_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q >= $past(cnt_q))
    else $error("step count went backward");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> per_sel != '0 && !div_stat.busy)
    else $error("divider started with zero period or while busy");

  a_one_load_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !out_load && in_stall_o == 1'b0)
    else $error("result loaded twice for one item");

endmodule

// ----- verif/output_aligned_time_stepper_top_tb.sv -----
// Self-checking testbench for output_aligned_time_stepper_top.
// Queue-fed driver, checking monitor and a local step predictor; uses otas_pkg.
// Steps the block through several register settings, random idling on both sides.
`timescale 1ns / 1ps

module output_aligned_time_stepper_top_tb;

  localparam int          LATENCY      = 3 * (32 + 3) + 4;
  localparam int          SETTLE       = LATENCY + 20;
  localparam int          CYCLE_LIMIT  = 1500000;
  localparam int          MAX_REPORTS  = 10;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_ITEMS  = 185;
  localparam logic [31:0] END_CAP      = 32'hB000_0000;

  typedef struct packed {
    logic [31:0] time_now;
    logic [31:0] step_taken;
    logic [31:0] step_number;
    logic        map_due;
    logic        log_due;
    logic        screen_due;
    logic        halt;
  } step_result_t;

  logic                           clk_i            = 1'b0;
  logic                           rst_ni           = 1'b0;
  logic                           cfg_we_i         = 1'b0;
  logic [otas_pkg::CFG_IDX_W-1:0] cfg_idx_i        = '0;
  logic [otas_pkg::CFG_W-1:0]     cfg_data_i       = '0;
  logic                           in_valid_i       = 1'b0;
  logic                           in_stall_o;
  logic [31:0]                    requested_step_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i      = 1'b0;
  logic [31:0]                    time_now_o;
  logic [31:0]                    step_taken_o;
  logic [31:0]                    step_number_o;
  logic                           map_due_o;
  logic                           log_due_o;
  logic                           screen_due_o;
  logic                           halt_o;

  // predictor copy of registers and state
  logic [31:0] end_cfg   = otas_pkg::RST_END_TIME;
  logic [31:0] limit_cfg = otas_pkg::RST_STEP_LIMIT;
  logic [31:0] period_cfg [otas_pkg::NUM_PER] = '{otas_pkg::RST_PERIOD, otas_pkg::RST_PERIOD,
                                                  otas_pkg::RST_PERIOD};
  logic [31:0] sim_time   = '0;
  logic [31:0] steps_done = '0;
  logic        halted     = 1'b0;

  logic [31:0]  pending_requests [$];
  step_result_t expected_steps [$];

  int send_idle_pct = 32;
  int recv_idle_pct = 46;
  int mismatch_cnt  = 0;
  int checked_cnt   = 0;
  int accepted_cnt  = 0;
  int setting_cnt   = 0;
  int cycle_cnt     = 0;

  output_aligned_time_stepper_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .requested_step_i (requested_step_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .time_now_o       (time_now_o),
    .step_taken_o     (step_taken_o),
    .step_number_o    (step_number_o),
    .map_due_o        (map_due_o),
    .log_due_o        (log_due_o),
    .screen_due_o     (screen_due_o),
    .halt_o           (halt_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // next deadline strictly above t; 0 when the period is zero or it overflows
  function automatic logic next_deadline(input logic [31:0] t, input logic [31:0] p,
                                         output logic [31:0] dl);
    logic [31:0] base;
    dl = '0;
    if (p == '0) return 1'b0;
    base = t - (t % p);
    if (p > 32'hFFFF_FFFF - base) return 1'b0;
    dl = base + p;
    return 1'b1;
  endfunction

  function automatic step_result_t advance_time(input logic [31:0] req);
    step_result_t r;
    logic [31:0]  dl [otas_pkg::NUM_PER];
    logic [2:0]   ok;
    logic [31:0]  target, sum, tn;
    target = end_cfg;
    for (int i = 0; i < otas_pkg::NUM_PER; i++) begin
      ok[i] = next_deadline(sim_time, period_cfg[i], dl[i]);
      if (ok[i] && dl[i] < target) target = dl[i];
    end
    sum = (req > 32'hFFFF_FFFF - sim_time) ? 32'hFFFF_FFFF : sim_time + req;
    tn  = (sum < target) ? sum : target;
    if (tn < sim_time) tn = sim_time;
    if (steps_done != 32'hFFFF_FFFF) steps_done++;
    if (steps_done >= limit_cfg || tn >= end_cfg) halted = 1'b1;
    r.time_now    = tn;
    r.step_taken  = tn - sim_time;
    r.step_number = steps_done;
    r.map_due     = ok[otas_pkg::PER_MAP] && tn == dl[otas_pkg::PER_MAP];
    r.log_due     = ok[otas_pkg::PER_LOG] && tn == dl[otas_pkg::PER_LOG];
    r.screen_due  = ok[otas_pkg::PER_SCREEN] && tn == dl[otas_pkg::PER_SCREEN];
    r.halt        = halted;
    sim_time      = tn;
    return r;
  endfunction

  function automatic string fmt_result(input step_result_t r);
    return $sformatf("time %0d taken %0d step %0d due m/l/s %b%b%b halt %b",
                     r.time_now, r.step_taken, r.step_number,
                     r.map_due, r.log_due, r.screen_due, r.halt);
  endfunction

  function automatic void check_result();
    step_result_t got, want;
    got = {time_now_o, step_taken_o, step_number_o, map_due_o, log_due_o, screen_due_o,
           halt_o};
    if (expected_steps.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("%0t: result with no step pending: %s", $time, fmt_result(got));
      return;
    end
    want = expected_steps.pop_front();
    checked_cnt++;
    if (got.time_now !== want.time_now || got.step_taken !== want.step_taken ||
        got.step_number !== want.step_number || got.map_due !== want.map_due ||
        got.log_due !== want.log_due || got.screen_due !== want.screen_due ||
        got.halt !== want.halt) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS) begin
        $display("%0t: mismatch on result %0d", $time, checked_cnt);
        $display("  expected %s", fmt_result(want));
        $display("  actual   %s", fmt_result(got));
      end
    end
  endfunction

  // driver: holds a stalled item, else presents the next one or idles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_steps.insert(expected_steps.size(), advance_time(requested_step_i));
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i       <= 1'b1;
          requested_step_i <= pending_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_steps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [otas_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      otas_pkg::CFG_END_TIME:      end_cfg = data;
      otas_pkg::CFG_MAP_PERIOD:    period_cfg[otas_pkg::PER_MAP] = data;
      otas_pkg::CFG_LOG_PERIOD:    period_cfg[otas_pkg::PER_LOG] = data;
      otas_pkg::CFG_SCREEN_PERIOD: period_cfg[otas_pkg::PER_SCREEN] = data;
      otas_pkg::CFG_STEP_LIMIT:    limit_cfg = data;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [31:0] end_t, map_p, log_p, scr_p, lim);
    write_reg(otas_pkg::CFG_END_TIME, end_t);
    write_reg(otas_pkg::CFG_MAP_PERIOD, map_p);
    write_reg(otas_pkg::CFG_LOG_PERIOD, log_p);
    write_reg(otas_pkg::CFG_SCREEN_PERIOD, scr_p);
    write_reg(otas_pkg::CFG_STEP_LIMIT, lim);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    setting_cnt++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_steps.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_request(input int sh);
    logic [31:0] span;
    span = 32'd1 << sh;
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      4, 5:    return $urandom_range(span);
      default: return $urandom_range(span >> 3);
    endcase
  endfunction

  function automatic logic [31:0] rand_period(input int sh);
    if ($urandom_range(5) == 0) return '0;
    return $urandom_range(32'd1 << sh, 1);
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_steps(input int count, input int sh);
    @(negedge clk_i);
    repeat (count) pending_requests.insert(pending_requests.size(), rand_request(sh));
    wait_idle();
  endtask

  initial begin
    int          sh;
    logic [63:0] end_sum;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings: clamp to deadlines, zero and saturating requests
    pending_requests = '{32'd0, 32'd3, 32'd4, 32'd5, 32'd10, 32'hFFFF_FFFF, 32'd1, 32'd9};
    wait_idle();
    // zero log period, mixed deadlines, halt from the step limit
    write_config(32'd5000, 32'd3, 32'd0, 32'd7, 32'd12);
    @(negedge clk_i);
    pending_requests = '{32'd2, 32'd0, 32'hFFFF_FFFF, 32'd4, 32'd1, 32'd100, 32'd1, 32'd1};
    wait_idle();
    // end time lowered below the current time: time holds
    write_config(32'd30, 32'd3, 32'd0, 32'd7, 32'd12);
    @(negedge clk_i);
    pending_requests = '{32'd5, 32'hFFFF_FFFF};
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      sh = 3 + ph * 25 / (RAND_PHASES - 1);
      if (ph == 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 32;
      end
      if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      end_sum = 64'(sim_time) + (64'd100 << sh);
      write_config(end_sum > 64'(END_CAP) ? END_CAP : end_sum[31:0],
                   rand_period(sh), rand_period(sh), rand_period(sh), rand_limit());
      random_steps(PHASE_ITEMS, sh);
    end

    write_config(sim_time >> 1, 32'd1, 32'd1, 32'd1, 32'd0);
    random_steps(40, 8);
    // top of the time range: deadlines overflow, sums saturate
    write_config(32'hFFFF_FFFF, 32'h4000_0000, 32'h6000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_steps(80, 28);
    write_config(32'd1, rand_period(10), rand_period(10), rand_period(10), 32'd1);
    random_steps(20, 10);

    $display("Summary: %0d steps over %0d register settings, %0d results checked",
             accepted_cnt, setting_cnt, checked_cnt);
    $display("Final time %0d ticks after %0d cycles, %0d mismatches",
             sim_time, cycle_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/otas_pkg.sv
sv/otas_div.sv
sv/output_aligned_time_stepper_top.sv
verif/output_aligned_time_stepper_top_tb.sv
